// ----- rtl/ipv4_longest_prefix_match_defines.svh -----
// Assertion macros shared by the prefix match modules.
`ifndef IPV4_LONGEST_PREFIX_MATCH_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_MATCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lpm_pkg.sv -----
// Types, constants and bit-count helpers for the IPv4 prefix match block.
package lpm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_W       = 5;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [3:0]        entry_index;
    logic [ADDR_W-1:0] address;
  } lpm_item_t;

  // Handshake between the queue head and the back end.
  typedef struct packed {
    logic      valid;
    lpm_item_t item;
  } lpm_head_t;

  // Number of zero bits above the highest set bit.
  function automatic logic [LEN_W-1:0] lead_zeros(input logic [ADDR_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = LEN_MAX;
    for (int i = 0; i < ADDR_W; i++) begin
      if (x[i]) n = LEN_W'(ADDR_W - 1 - i);
    end
    return n;
  endfunction

  // Number of zero bits below the lowest set bit.
  function automatic logic [LEN_W-1:0] trail_zeros(input logic [ADDR_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = LEN_MAX;
    for (int i = ADDR_W - 1; i >= 0; i--) begin
      if (x[i]) n = LEN_W'(i);
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (LEN_MAX - len);
    end
    return m;
  endfunction

endpackage

// ----- rtl/lpm_front.sv -----
// Input stage: accepts beats, tags them as write or lookup, and queues them.
`include "ipv4_longest_prefix_match_defines.svh"

module lpm_front import lpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [3:0]        entry_index,
  input  logic [ADDR_W-1:0] address,
  output lpm_head_t         head,
  input  logic              pop
);

  lpm_item_t       q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] fill;
  logic            push;
  lpm_item_t       item_in;

  assign in_stall = (fill == Q_CW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    item_in.kind        = func ? KIND_LOOKUP : KIND_WRITE;
    item_in.entry_index = entry_index;
    item_in.address     = address;
  end

  assign head.valid = (fill != '0);
  assign head.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `LPM_ASSERT_NOW(a_pop_nonempty, pop, fill != '0, "queue popped while empty")
  `LPM_ASSERT_NOW(a_fill_bound, 1'b1, fill <= Q_CW'(Q_DEPTH), "queue fill out of range")

endmodule

// ----- rtl/lpm_back.sv -----
// Back end: address table, sequential entry scan and result register.
`include "ipv4_longest_prefix_match_defines.svh"

module lpm_back import lpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_data,
  input  lpm_head_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  prefix_length,
  output logic [ADDR_W-1:0] network_address,
  output logic              hit
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  entries_in_use;
  logic [CFG_W-1:0]  active;
  logic [CFG_W-1:0]  scan_idx;
  logic [CFG_W-1:0]  scan_last;
  logic [ADDR_W-1:0] query;
  logic [ADDR_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data;
  logic [TBL_AW-1:0] rd_addr;
  logic              best_hit;
  logic [LEN_W-1:0]  best_len;
  logic [LEN_W-1:0]  lz;
  logic [LEN_W-1:0]  tz;
  logic              is_match;
  logic              better;
  logic              out_free;
  logic [LEN_W-1:0]  res_len;

  assign active = (entries_in_use > CFG_W'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH) : entries_in_use;
  assign pop    = (state == ST_IDLE) && head.valid;
  assign out_free = !out_valid || !out_stall;

  // Entry e matches the query at length L when the top L bits agree and e has
  // no set bits below L. Its best length is therefore the common prefix length,
  // provided that covers every set bit of e.
  assign lz       = lead_zeros(query ^ rd_data);
  assign tz       = trail_zeros(rd_data);
  assign is_match = ({1'b0, lz} + {1'b0, tz}) >= {1'b0, LEN_MAX};
  assign better   = is_match && (!best_hit || (lz > best_len));
  assign res_len  = best_hit ? best_len : '0;

  assign rd_addr = pop ? '0 : scan_idx[TBL_AW-1:0] + 1'b1;

  always_ff @(posedge clk) begin
    if (pop && (head.item.kind == KIND_WRITE) &&
        ({1'b0, head.item.entry_index} < 5'(TABLE_DEPTH))) begin
      tbl_mem[head.item.entry_index[TBL_AW-1:0]] <= head.item.address;
    end
    rd_data <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= '0;
      out_valid      <= 1'b0;
      best_hit       <= 1'b0;
    end else begin
      if (cfg_write) entries_in_use <= cfg_data;
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && (head.item.kind == KIND_LOOKUP)) begin
            best_hit <= 1'b0;
            state    <= (active == '0) ? ST_EMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (better) best_hit <= 1'b1;
          if (scan_idx == scan_last) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      query     <= head.item.address;
      scan_idx  <= '0;
      scan_last <= active - 1'b1;
      best_len  <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (better) best_len <= lz;
    end
    if ((state == ST_EMIT) && out_free) begin
      prefix_length   <= res_len;
      network_address <= query & prefix_mask(res_len);
      hit             <= best_hit;
    end
  end

  `LPM_ASSERT_NOW(a_scan_bound, state == ST_SCAN, scan_idx <= scan_last, "scan ran past the last entry")
  `LPM_ASSERT_NOW(a_best_len, best_hit, best_len <= LEN_MAX, "best prefix length above 32")
  `LPM_ASSERT_NOW(a_miss_zero, out_valid && !hit, prefix_length == '0 && network_address == '0, "miss result not zero")

endmodule

// ----- rtl/ipv4_longest_prefix_match.sv -----
// IPv4 longest prefix match over a small table of network addresses.
//
// Items enter on in_valid/in_stall with func, entry_index and address. A beat
// with func 0 stores address in slot entry_index and yields no result; a beat
// with func 1 looks address up and yields one result beat on out_valid/
// out_stall carrying prefix_length, network_address and hit.
// The table size in use is set through cfg_valid/cfg_ready/entries_in_use and
// is to be written by the user only while no item is in flight; the block
// does not enforce this. cfg_ready is always high. A two-deep queue decouples
// input from the scan, so beats are taken while a lookup is being worked on or
// a result waits. Writes retire one per cycle while no lookup is in progress.
// A lookup reads one table entry per cycle from the single table read port,
// and no further item leaves the queue until the lookup result is registered.
// While out_stall is high the result is held and the scan of the next lookup
// completes, then waits; the queue fills and in_stall rises.
// Reset clears the queue, out_valid and entries_in_use. Table
// slots are undefined until written and must be written before use.
module ipv4_longest_prefix_match import lpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  entries_in_use,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [3:0]        entry_index,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  prefix_length,
  output logic [ADDR_W-1:0] network_address,
  output logic              hit
);

  lpm_head_t head;
  logic      pop;

  assign cfg_ready = 1'b1;

  lpm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .entry_index (entry_index),
    .address     (address),
    .head        (head),
    .pop         (pop)
  );

  lpm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (entries_in_use),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .prefix_length   (prefix_length),
    .network_address (network_address),
    .hit             (hit)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the IPv4 longest prefix match block.
`timescale 1ns / 100ps

module tb_top;
  import lpm_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int IDLE_PCT      = 21;

  typedef struct packed {
    logic [LEN_W-1:0]  prefix_length;
    logic [ADDR_W-1:0] network_address;
    logic              hit;
  } route_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_entries;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [3:0]        entry_index;
  logic [ADDR_W-1:0] address;
  logic              out_valid;
  logic              out_stall;
  logic [LEN_W-1:0]  prefix_length;
  logic [ADDR_W-1:0] network_address;
  logic              hit;

  // Shadow copy of the table and the size register.
  logic [ADDR_W-1:0] route_table [TABLE_DEPTH];
  logic [CFG_W-1:0]  entries_cfg;
  route_result_t     pending_results [$];
  int                mismatch_count;
  int                cycle_count;
  bit                no_idle;

  ipv4_longest_prefix_match dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .entries_in_use  (cfg_entries),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .entry_index     (entry_index),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .prefix_length   (prefix_length),
    .network_address (network_address),
    .hit             (hit)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic logic [ADDR_W-1:0] net_mask(input int unsigned len);
    logic [ADDR_W-1:0] m;
    if (len == 0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (ADDR_W - len);
    end
    return m;
  endfunction

  function automatic int unsigned active_count();
    int unsigned cnt;
    cnt = entries_cfg;
    if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
    return cnt;
  endfunction

  // Try lengths from the longest down; the first length where some entry in
  // use equals the masked query wins.
  function automatic route_result_t match_longest_prefix(input logic [ADDR_W-1:0] query);
    route_result_t     res;
    logic [ADDR_W-1:0] net;
    int unsigned       cnt;
    cnt = active_count();
    res = '0;
    for (int len = ADDR_W; len >= 0; len--) begin
      net = query & net_mask(len);
      for (int unsigned n = 0; n < cnt; n++) begin
        if (route_table[n] == net) begin
          res.prefix_length   = LEN_W'(len);
          res.network_address = net;
          res.hit             = 1'b1;
          return res;
        end
      end
    end
    return res;
  endfunction

  // A network address with a random length, now and then a plain host.
  function automatic logic [ADDR_W-1:0] pick_network();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 15) return $urandom;
    return $urandom & net_mask($urandom_range(1, ADDR_W - 1));
  endfunction

  // Most queries fall inside or next to a table entry so that hits at many
  // lengths show up; the rest are random addresses.
  function automatic logic [ADDR_W-1:0] pick_query();
    int unsigned       sel;
    int unsigned       cnt;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] m;
    cnt = active_count();
    sel = $urandom_range(99);
    if (cnt == 0 || sel < 20) return $urandom;
    base = route_table[$urandom_range(cnt - 1)];
    if (sel < 35) return base ^ (32'h1 << $urandom_range(ADDR_W - 1));
    m = net_mask($urandom_range(ADDR_W));
    return (base & m) | ($urandom & ~m);
  endfunction

  task automatic send_item(input item_kind_e kind, input logic [3:0] idx,
                           input logic [ADDR_W-1:0] addr);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    func        <= kind;
    entry_index <= idx;
    address     <= addr;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_WRITE) begin
      route_table[idx] = addr;
    end else begin
      pending_results.push_back(match_longest_prefix(addr));
    end
  endtask

  // Writes leave no result behind, so give the block time to retire them.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entries_in_use(input logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_valid   <= 1'b1;
    cfg_entries <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    entries_cfg = value;
  endtask

  task automatic test_empty_table();
    set_entries_in_use('0);
    send_item(KIND_LOOKUP, 4'd0, 32'h0000_0000);
    send_item(KIND_LOOKUP, 4'd15, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 4'd5, 32'h0A00_0001);
  endtask

  task automatic test_table_fill();
    send_item(KIND_WRITE, 4'd0, 32'hFFFF_FFFF);
    send_item(KIND_WRITE, 4'd1, 32'hC0A8_0100);
    send_item(KIND_WRITE, 4'd2, 32'hC0A8_0000);
    send_item(KIND_WRITE, 4'd3, 32'h0A00_0000);
    for (int i = 4; i < TABLE_DEPTH - 1; i++) begin
      send_item(KIND_WRITE, 4'(i), pick_network());
    end
    // The default route in the last slot matches anything at length zero.
    send_item(KIND_WRITE, 4'd15, 32'h0000_0000);
  endtask

  task automatic test_depth_limits();
    set_entries_in_use(CFG_W'(TABLE_DEPTH));
    send_item(KIND_LOOKUP, 4'd0, 32'hC0A8_0105);
    send_item(KIND_LOOKUP, 4'd9, 32'hC0A8_FF01);
    send_item(KIND_LOOKUP, 4'd15, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 4'd3, 32'h0B00_0000);
    // A size above the table depth is clamped to the depth.
    set_entries_in_use('1);
    send_item(KIND_LOOKUP, 4'd2, 32'h0A01_0203);
    set_entries_in_use(CFG_W'(2));
    send_item(KIND_LOOKUP, 4'd7, 32'h0A00_0001);
  endtask

  task automatic run_traffic(input logic [CFG_W-1:0] cfg, input int items, input bit quiet);
    set_entries_in_use(cfg);
    no_idle = quiet;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 12) begin
        send_item(KIND_WRITE, 4'($urandom_range(15)), pick_network());
      end else begin
        send_item(KIND_LOOKUP, 4'($urandom_range(15)), pick_query());
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_traffic(CFG_W'(TABLE_DEPTH), 90, 1'b0);
    run_traffic('1, 80, 1'b0);
    run_traffic(CFG_W'(1), 70, 1'b0);
    run_traffic('0, 50, 1'b0);
    run_traffic(CFG_W'($urandom_range(2, TABLE_DEPTH - 1)), 80, 1'b0);
    run_traffic(CFG_W'($urandom_range(TABLE_DEPTH + 1, 31)), 50, 1'b0);
    run_traffic(CFG_W'(TABLE_DEPTH), 90, 1'b1);
  endtask

  // Result side: random backpressure, and each beat checked in order.
  always @(posedge clk) begin
    route_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no lookup outstanding: prefix_length %0d address %h",
               prefix_length, network_address);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (prefix_length !== exp_res.prefix_length) begin
          $error("prefix_length: expected %0d, got %0d", exp_res.prefix_length, prefix_length);
          mismatch_count++;
        end
        if (network_address !== exp_res.network_address) begin
          $error("network_address: expected %h, got %h",
                 exp_res.network_address, network_address);
          mismatch_count++;
        end
        if (hit !== exp_res.hit) begin
          $error("hit: expected %0b, got %0b", exp_res.hit, hit);
          mismatch_count++;
        end
      end
    end
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_entries    = '0;
    in_valid       = 1'b0;
    func           = 1'b0;
    entry_index    = '0;
    address        = '0;
    out_stall      = 1'b0;
    entries_cfg    = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    no_idle        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_table_fill();
    test_depth_limits();
    test_random_traffic();
    wait_for_idle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lpm_pkg.sv
rtl/lpm_front.sv
rtl/lpm_back.sv
rtl/ipv4_longest_prefix_match.sv
tb/sv/tb_top.sv
